// File: design/b2d_pkg.sv
`timescale 1ns / 1ps

package b2d_pkg;

  localparam int unsigned POS_COUNT  = 10;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned STEP_W     = 2;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 6;

  localparam logic [POS_W-1:0]  LAST_POS   = 4'd9;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

  localparam logic [VALUE_W-1:0] POW10 [POS_COUNT] = '{
    32'd1000000000, 32'd100000000, 32'd10000000, 32'd1000000, 32'd100000,
    32'd10000, 32'd1000, 32'd100, 32'd10, 32'd1
  };

  typedef struct packed {
    logic start;
    logic shift;
  } cell_ctl_t;

endpackage

// File: design/b2d_num_if.sv
`timescale 1ns / 1ps

interface b2d_num_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// File: design/b2d_txt_if.sv
`timescale 1ns / 1ps

interface b2d_txt_if;
  logic       valid;
  logic       ready;
  logic [5:0] digit_char;
  logic       last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink (input valid, input digit_char, input last_digit, output ready);
endinterface

// File: design/binary_to_decimal_ascii.sv
// Each accepted number runs through the ten digit cells in turn, each taking four
// compare-subtract steps; skipped leading zeros then each take an emit step
// without a character before the first character shows. A new number is
// accepted only once idle, after all ten positions have shifted out.
// Reset (rst, synchronous) clears the sequencer, cell step counters and output
// valid; remainders and digits are reloaded with each number.
`timescale 1ns / 1ps

module binary_to_decimal_ascii (
  input  logic         clk,
  input  logic         rst,
  b2d_num_if.sink      number,
  b2d_txt_if.source    text
);
  import b2d_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state;
  logic [POS_W-1:0]   pos;
  logic               started;
  logic               out_valid;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;

  logic               accept;
  logic               load_ok;
  logic               advance;
  logic               take;
  logic [DIGIT_W-1:0] head;

  logic [VALUE_W-1:0] rem_link   [POS_COUNT];
  logic [DIGIT_W-1:0] digit_link [POS_COUNT+1];
  logic               done_link  [POS_COUNT];
  cell_ctl_t          cell_ctl   [POS_COUNT];

  assign number.ready = (state == ST_IDLE);
  assign accept       = number.valid && number.ready;
  assign load_ok      = !out_valid || text.ready;
  assign advance      = (state == ST_EMIT) && load_ok;
  assign head         = digit_link[0];
  assign take         = (head != '0) || started || (pos == LAST_POS);

  assign rem_link[0]                = number.value;
  assign digit_link[POS_COUNT]      = '0;

  genvar k;
  generate
    for (k = 0; k < POS_COUNT; k++) begin : g_cell
      if (k == 0) begin : g_first
        assign cell_ctl[k].start = accept;
      end else begin : g_next
        assign cell_ctl[k].start = done_link[k-1];
      end
      assign cell_ctl[k].shift = advance;

      if (k == POS_COUNT - 1) begin : g_tail
        b2d_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .ctl      (cell_ctl[k]),
          .power    (POW10[k]),
          .rem_in   (rem_link[k]),
          .digit_in (digit_link[k+1]),
          .rem_out  (),
          .digit    (digit_link[k]),
          .done     (done_link[k])
        );
      end else begin : g_body
        b2d_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .ctl      (cell_ctl[k]),
          .power    (POW10[k]),
          .rem_in   (rem_link[k]),
          .digit_in (digit_link[k+1]),
          .rem_out  (rem_link[k+1]),
          .digit    (digit_link[k]),
          .done     (done_link[k])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (done_link[POS_COUNT-1]) begin
            state   <= ST_EMIT;
            pos     <= '0;
            started <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (advance) begin
            pos <= pos + 1'b1;
            if (head != '0) begin
              started <= 1'b1;
            end
            if (pos == LAST_POS) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Hold the character until taken; drop valid once the transaction completes
      if (advance && take) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && take) begin
      out_char <= ASCII_ZERO + {2'b00, head};
      out_last <= (pos == LAST_POS);
    end
  end

  assign text.valid      = out_valid;
  assign text.digit_char = out_char;
  assign text.last_digit = out_last;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CONV))
    else $error("accepted number did not start conversion");

  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    done_link[POS_COUNT-1] |-> (state == ST_CONV))
    else $error("digit chain finished outside conversion");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    text.valid |-> ((text.digit_char >= ASCII_ZERO) && (text.digit_char <= ASCII_NINE)))
    else $error("character is not a decimal digit");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (advance && (pos == LAST_POS)) |=> (state == ST_IDLE) && text.valid && text.last_digit)
    else $error("last position did not end the run");
`endif

endmodule

// File: design/b2d_cell.sv
`timescale 1ns / 1ps

module b2d_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  b2d_pkg::cell_ctl_t    ctl,
  input  logic [31:0]           power,
  input  logic [31:0]           rem_in,
  input  logic [3:0]            digit_in,
  output logic [31:0]           rem_out,
  output logic [3:0]            digit,
  output logic                  done
);
  import b2d_pkg::*;

  logic [VALUE_W-1:0]   rem;
  logic [STEP_W-1:0]    step;
  logic                 active;
  logic [VALUE_W+1:0]   trial;
  logic                 fits;

  // One quotient bit per cycle: try power * 8, 4, 2, 1 in turn
  assign trial   = {2'b00, power} << step;
  assign fits    = {2'b00, rem} >= trial;
  assign rem_out = fits ? (rem - trial[VALUE_W-1:0]) : rem;
  assign done    = active && (step == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= '0;
    end else if (ctl.start) begin
      active <= 1'b1;
      step   <= '1;
    end else if (active) begin
      step <= step - 1'b1;
      if (step == '0) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem   <= rem_in;
      digit <= '0;
    end else if (active) begin
      rem         <= rem_out;
      digit[step] <= fits;
    end else if (ctl.shift) begin
      digit <= digit_in;
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import b2d_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 60;
  localparam int CORNER_COUNT = 22;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } digit_char_t;

  logic clk;
  logic rst;
  bit   quiet;

  b2d_num_if num_bus ();
  b2d_txt_if txt_bus ();

  binary_to_decimal_ascii u_dut (
    .clk    (clk),
    .rst    (rst),
    .number (num_bus),
    .text   (txt_bus)
  );

  // Holds the decimal characters still owed for every number taken in.
  class digit_scoreboard;
    digit_char_t        owed_chars[$];
    logic [VALUE_W-1:0] pow_ten[POS_COUNT];
    int                 errors;
    int                 numbers_seen;
    int                 chars_seen;
    int                 ten_digit_numbers;

    function new();
      pow_ten[0] = 1;
      for (int i = 1; i < POS_COUNT; i++) begin
        pow_ten[i] = pow_ten[i-1] * 10;
      end
    endfunction

    function void note_number(logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] rest;
      logic [CHAR_W-1:0]  digit;
      bit                 started;
      int                 pos;
      int                 count;
      digit_char_t        c;
      rest    = value;
      started = 1'b0;
      count   = 0;
      for (pos = int'(POS_COUNT) - 1; pos >= 0; pos--) begin
        digit = '0;
        while (rest >= pow_ten[pos]) begin
          rest  -= pow_ten[pos];
          digit += 1'b1;
        end
        if (digit != 0) started = 1'b1;
        // drop leading zeros, but always emit the ones digit
        if (started || pos == 0) begin
          c.digit_char = ASCII_ZERO + digit;
          c.last_digit = (pos == 0);
          owed_chars.push_back(c);
          count++;
        end
      end
      numbers_seen++;
      if (count == int'(POS_COUNT)) ten_digit_numbers++;
    endfunction

    function void check_char(logic [CHAR_W-1:0] digit_char, logic last_digit);
      digit_char_t c;
      chars_seen++;
      if (owed_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected character, got digit_char %0d last_digit %0b",
                 $time, digit_char, last_digit);
        return;
      end
      c = owed_chars.pop_front();
      if (digit_char !== c.digit_char) begin
        errors++;
        $display("%0t: digit_char expected %0d got %0d", $time, c.digit_char, digit_char);
      end
      if (last_digit !== c.last_digit) begin
        errors++;
        $display("%0t: last_digit expected %0b got %0b", $time, c.last_digit, last_digit);
      end
    endfunction
  endclass

  digit_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && num_bus.valid && num_bus.ready) sb.note_number(num_bus.value);
  end

  always @(posedge clk) begin
    if (!rst && txt_bus.valid && txt_bus.ready)
      sb.check_char(txt_bus.digit_char, txt_bus.last_digit);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("binary_to_decimal_ascii: mismatch");
    $finish;
  end

  function automatic int draw_wait();
    return quiet ? 0 : int'($urandom_range(4, 0));
  endfunction

  // Mostly digit strings biased toward 0 and 9, plus raw and tiny values.
  function automatic logic [VALUE_W-1:0] pick_number();
    logic [63:0] acc;
    int          mode;
    int          len;
    int          r;
    int          d;
    mode = $urandom_range(9, 0);
    if (mode < 2) return $urandom;
    if (mode == 2) return $urandom_range(20, 0);
    acc = 0;
    len = $urandom_range(10, 1);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(3, 0);
      d = (r == 0) ? 0 : (r == 1) ? 9 : int'($urandom_range(9, 0));
      acc = acc * 10 + d;
    end
    if (acc > 64'hFFFF_FFFF) acc = acc % 1000000000 + 64'd1000000000 * $urandom_range(3, 1);
    return acc[VALUE_W-1:0];
  endfunction

  task automatic send_number(input logic [VALUE_W-1:0] value);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      num_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    num_bus.valid <= 1'b1;
    num_bus.value <= value;
    do @(posedge clk); while (!num_bus.ready);
  endtask

  task automatic drain_chars();
    int stall;
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        txt_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      txt_bus.ready <= 1'b1;
      do @(posedge clk); while (!txt_bus.valid);
    end
  endtask

  initial begin
    logic [VALUE_W-1:0] corner_values [CORNER_COUNT];
    int phase;
    corner_values = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd19, 32'd99, 32'd100, 32'd101,
      32'd999, 32'd1000, 32'd9999, 32'd100000, 32'd99999999, 32'd999999999,
      32'd1000000000, 32'd1234567890, 32'd2147483647, 32'd2147483648,
      32'd4000000000, 32'd4294967294, 32'd4294967295
    };
    rst           <= 1'b1;
    num_bus.valid <= 1'b0;
    num_bus.value <= '0;
    txt_bus.ready <= 1'b0;
    quiet = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_chars();
    join_none

    for (int i = 0; i < CORNER_COUNT; i++) send_number(corner_values[i]);

    // first phase runs back to back on both sides, the rest idle at random
    for (phase = 0; phase < 4; phase++) begin
      quiet = (phase == 0);
      repeat (phase == 0 ? 20 : 29) send_number(pick_number());
    end
    num_bus.valid <= 1'b0;

    while (sb.owed_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("converted %0d numbers into %0d characters, %0d of them ten digits long",
             sb.numbers_seen, sb.chars_seen, sb.ten_digit_numbers);
    $display("covered zero, powers of ten and their neighbors, the 32-bit extremes");
    if (sb.errors == 0 && sb.owed_chars.size() == 0) begin
      $display("binary_to_decimal_ascii: match");
    end else begin
      $display("%0d errors, %0d characters never arrived", sb.errors, sb.owed_chars.size());
      $display("binary_to_decimal_ascii: mismatch");
    end
    $finish;
  end

endmodule
